// ===== rtl/core/dpt_pkg.sv =====
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared widths, codes and types of the device presence table.
// ----------------------------------------------------------------------------
package dpt_pkg;

    // default table depth
    localparam int TABLE_ENTRIES_DEF = 32;

    // field widths
    localparam int ADDR_W   = 48;
    localparam int STR_W    = 10;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 5;
    localparam int COUNT_W  = 6;
    localparam int SEQ_W    = 32;
    localparam int TMO_W    = 16;
    localparam int TOP_W    = 32;

    // configuration bus
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 3;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_UPPER_LIMIT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOWER_LIMIT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TYPE_FIRST  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TYPE_SECOND = 3'd4;

    // register reset values
    localparam logic [TMO_W-1:0]  TIMEOUT_RST     = 16'd3;
    localparam logic [STR_W-1:0]  UPPER_LIMIT_RST = 10'sd128;
    localparam logic [STR_W-1:0]  LOWER_LIMIT_RST = -10'sd256;
    localparam logic [KIND_W-1:0] TYPE_FIRST_RST  = 2'd2;
    localparam logic [KIND_W-1:0] TYPE_SECOND_RST = 2'd3;

    // operation codes
    localparam logic OP_REPORT   = 1'b0;
    localparam logic OP_NEW_SCAN = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ADVANCED = 3'd4;

    // configuration register set
    typedef struct packed {
        logic [TMO_W-1:0]        timeout;
        logic signed [STR_W-1:0] upper_limit;
        logic signed [STR_W-1:0] lower_limit;
        logic [KIND_W-1:0]       type_first;
        logic [KIND_W-1:0]       type_second;
    } t_cfg;

    // one table entry as stored
    typedef struct packed {
        logic [SEQ_W-1:0]  seen_seq;
        logic [ADDR_W-1:0] address;
    } t_entry;

endpackage

// ===== rtl/core/dpt_in_if.sv =====
// ----------------------------------------------------------------------------
// dpt_in_if
// Report channel: valid/ready handshake with one report word.
// ----------------------------------------------------------------------------
interface dpt_in_if import dpt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [ADDR_W-1:0]       device_address;
    logic signed [STR_W-1:0] signal_strength;
    logic [KIND_W-1:0]       device_kind;
    logic                    scan_complete;

    modport source (
        output valid, operation, device_address, signal_strength, device_kind,
               scan_complete,
        input  ready
    );
    modport sink (
        input  valid, operation, device_address, signal_strength, device_kind,
               scan_complete,
        output ready
    );
endinterface

// ===== rtl/core/dpt_out_if.sv =====
// ----------------------------------------------------------------------------
// dpt_out_if
// Result channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface dpt_out_if import dpt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [COUNT_W-1:0]  entry_count;

    modport source (
        output valid, status, slot_index, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, slot_index, entry_count,
        output ready
    );
endinterface

// ===== rtl/core/dpt_cfg.sv =====
// ----------------------------------------------------------------------------
// dpt_cfg
// APB register file holding the filter window, accepted types and timeout.
// ----------------------------------------------------------------------------
module dpt_cfg import dpt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // register writes, values cut to the register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout     <= TIMEOUT_RST;
            r_cfg.upper_limit <= UPPER_LIMIT_RST;
            r_cfg.lower_limit <= LOWER_LIMIT_RST;
            r_cfg.type_first  <= TYPE_FIRST_RST;
            r_cfg.type_second <= TYPE_SECOND_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_TIMEOUT:     r_cfg.timeout     <= pwdata[TMO_W-1:0];
                REG_UPPER_LIMIT: r_cfg.upper_limit <= pwdata[STR_W-1:0];
                REG_LOWER_LIMIT: r_cfg.lower_limit <= pwdata[STR_W-1:0];
                REG_TYPE_FIRST:  r_cfg.type_first  <= pwdata[KIND_W-1:0];
                REG_TYPE_SECOND: r_cfg.type_second <= pwdata[KIND_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            REG_TIMEOUT:     prdata = PDATA_W'(r_cfg.timeout);
            REG_UPPER_LIMIT: prdata = PDATA_W'(r_cfg.upper_limit);
            REG_LOWER_LIMIT: prdata = PDATA_W'(r_cfg.lower_limit);
            REG_TYPE_FIRST:  prdata = PDATA_W'(r_cfg.type_first);
            REG_TYPE_SECOND: prdata = PDATA_W'(r_cfg.type_second);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/dpt_mem.sv =====
// ----------------------------------------------------------------------------
// dpt_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dpt_mem import dpt_pkg::*; #(
    parameter int DEPTH = TABLE_ENTRIES_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dpt_seq.sv =====
// ----------------------------------------------------------------------------
// dpt_seq
// Sequencer: filters a report, walks the table for a match and a free slot and,
// if it ends a scan, walks it again to age out stale entries, one entry at a time.
// ----------------------------------------------------------------------------
module dpt_seq import dpt_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int IDX_W = $clog2(TABLE_ENTRIES),
    parameter int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    dpt_in_if.sink           i_in,
    dpt_out_if.source        o_out,
    output logic             o_wr_en,
    output logic [IDX_W-1:0] o_waddr,
    output t_entry           o_wdata,
    output logic             o_rd_en,
    output logic [IDX_W-1:0] o_raddr,
    input  t_entry           i_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MATCH,
        S_SWEEP,
        S_AGE,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [IDX_W:0]      r_idx;
    logic [IDX_W-1:0]    r_free;
    logic                r_free_found;
    logic [IDX_W-1:0]    r_slot;
    logic [STATUS_W-1:0] r_status;
    logic                r_purge;
    logic [ADDR_W-1:0]   r_addr;
    logic [SEQ_W-1:0]    r_seq;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_n;
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [COUNT_W-1:0]  r_out_count;

    logic                in_fire;
    logic                out_free;
    logic                idx_end;
    logic [IDX_W-1:0]    cur;
    logic                cur_valid;
    logic                rejected;
    logic                addr_hit;
    logic                stale;
    logic [SEQ_W-1:0]    age_sum;
    logic [31:0]         slot_ext;
    logic [31:0]         count_ext;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid & i_in.ready;
    assign out_free   = ~r_out_valid | o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.slot_index  = r_out_slot;
    assign o_out.entry_count = r_out_count;

    // walk position
    assign idx_end   = (r_idx == (IDX_W+1)'(TABLE_ENTRIES));
    assign cur       = r_idx[IDX_W-1:0];
    assign cur_valid = r_valid[cur] & ~idx_end;

    // report filter
    assign rejected = ($signed(i_in.signal_strength) > $signed(i_cfg.upper_limit))
                   || ($signed(i_in.signal_strength) < $signed(i_cfg.lower_limit))
                   || ((i_in.device_kind != i_cfg.type_first)
                       && (i_in.device_kind != i_cfg.type_second))
                   || (i_in.device_address[ADDR_W-1:ADDR_W-TOP_W] == '1);

    // shared compare unit on the read entry
    assign addr_hit = (i_rdata.address == r_addr);
    assign age_sum  = i_rdata.seen_seq + SEQ_W'(i_cfg.timeout);
    assign stale    = (age_sum < r_seq);

    // result fields cut to port width
    assign slot_ext  = 32'(r_slot);
    assign count_ext = 32'(r_count);

    // memory access
    always_comb begin
        o_rd_en = ((r_state == S_SEARCH) || (r_state == S_SWEEP)) && cur_valid;
        o_raddr = cur;
        o_wdata = '{seen_seq: r_seq, address: r_addr};
        o_wr_en = 1'b0;
        o_waddr = cur;
        if (r_state == S_SEARCH && idx_end && r_free_found) begin
            o_wr_en = 1'b1;
            o_waddr = r_free;
        end else if (r_state == S_MATCH && addr_hit) begin
            o_wr_en = 1'b1;
        end
    end

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_free       <= '0;
            r_free_found <= 1'b0;
            r_slot       <= '0;
            r_status     <= ST_IGNORED;
            r_purge      <= 1'b0;
            r_seq        <= '0;
            r_count      <= '0;
            r_n          <= '0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
            r_out_status <= ST_IGNORED;
            r_out_slot   <= '0;
            r_out_count  <= '0;
        end else begin
            // output register fill and drain
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_addr       <= i_in.device_address;
                        r_purge      <= i_in.scan_complete;
                        r_slot       <= '0;
                        r_idx        <= '0;
                        r_n          <= '0;
                        r_free_found <= 1'b0;
                        if (i_in.operation == OP_NEW_SCAN) begin
                            r_seq    <= r_seq + SEQ_W'(1);
                            r_status <= ST_ADVANCED;
                            r_state  <= S_DONE;
                        end else if (rejected) begin
                            r_status <= ST_IGNORED;
                            r_state  <= i_in.scan_complete ? S_SWEEP : S_DONE;
                        end else begin
                            r_state <= S_SEARCH;
                        end
                    end
                end
                // look for the same address, remember the lowest free slot
                S_SEARCH: begin
                    if (idx_end) begin
                        if (r_free_found) begin
                            r_valid[r_free] <= 1'b1;
                            r_count         <= r_count + CNT_W'(1);
                            r_slot          <= r_free;
                            r_status        <= ST_INSERTED;
                        end else begin
                            r_slot   <= '0;
                            r_status <= ST_FULL;
                        end
                        r_idx   <= '0;
                        r_state <= r_purge ? S_SWEEP : S_DONE;
                    end else if (cur_valid) begin
                        r_state <= S_MATCH;
                    end else begin
                        if (!r_free_found) begin
                            r_free       <= cur;
                            r_free_found <= 1'b1;
                        end
                        r_idx <= r_idx + (IDX_W+1)'(1);
                    end
                end
                S_MATCH: begin
                    if (addr_hit) begin
                        r_slot   <= cur;
                        r_status <= ST_UPDATED;
                        r_idx    <= '0;
                        r_state  <= r_purge ? S_SWEEP : S_DONE;
                    end else begin
                        r_idx   <= r_idx + (IDX_W+1)'(1);
                        r_state <= S_SEARCH;
                    end
                end
                // aging walk and recount
                S_SWEEP: begin
                    if (idx_end) begin
                        r_count <= r_n;
                        r_state <= S_DONE;
                    end else if (cur_valid) begin
                        r_state <= S_AGE;
                    end else begin
                        r_idx <= r_idx + (IDX_W+1)'(1);
                    end
                end
                S_AGE: begin
                    if (stale) begin
                        r_valid[cur] <= 1'b0;
                    end else begin
                        r_n <= r_n + CNT_W'(1);
                    end
                    r_idx   <= r_idx + (IDX_W+1)'(1);
                    r_state <= S_SWEEP;
                end
                // hand the result word to the output register
                S_DONE: begin
                    if (out_free) begin
                        r_out_status <= r_status;
                        r_out_slot   <= slot_ext[SLOT_W-1:0];
                        r_out_count  <= count_ext[COUNT_W-1:0];
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/device_presence_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// device_presence_table_with_aging
// Table of seen radio devices with strength/type filtering and aging.
// ----------------------------------------------------------------------------
// One item is in work at a time and the input is not ready meanwhile. A
// new-scan word, or an ignored report that does not end a scan, goes straight
// to its result. A kept report walks the table for a matching address and the
// lowest free slot, stopping at the first match; a report that ends a scan then
// walks the whole table again to age out stale entries and recount. In each
// walk a valid slot is fetched from the single-read-port entry memory and then
// checked, while a free slot is only stepped over. The result word sits in an
// output register, so a new word is taken while the last result waits; a
// finished result that finds that register still full waits in place until
// it drains. No clearing pass is needed after reset.
module device_presence_table_with_aging import dpt_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dpt_in_if.sink             i_in,
    dpt_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    t_cfg             cfg;
    logic             wr_en;
    logic [IDX_W-1:0] waddr;
    t_entry           wdata;
    logic             rd_en;
    logic [IDX_W-1:0] raddr;
    t_entry           rdata;

    // configuration registers
    dpt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // entry store
    dpt_mem #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_wr_en (wr_en),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_rd_en (rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // sequencer
    dpt_seq #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_wr_en (wr_en),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_rd_en (rd_en),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

endmodule
